// ----- hw/rtl/pbf_pkg.sv -----
// Shared constants for the pair Bloom filter: hash multipliers, the pair offset,
// the default filter size, the bit store row width and the action codes.
// No dependencies; used by pbf_hash and pair_bloom_filter.
package pbf_pkg;

    // Offset added to the packed pair for the second hash.
    localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;

    // Finalizer multipliers of the 64-bit mixing function.
    localparam logic [63:0] MIX_C1 = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] MIX_C2 = 64'hC4CE_B9FE_1A85_EC53;

    // Default filter size in bits (power of two, 64 to 1048576).
    localparam int unsigned FILTER_BITS_DEF = 65536;

    // Width of one row of the bit store.
    localparam int unsigned ROW_BITS = 32;

    // Action codes of an input transaction.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TEST   = 1'b1;

endpackage

// ----- hw/rtl/pair_bloom_filter.sv -----
// Top level of the pair Bloom filter: input and result channels, sequencer,
// bit store and the two hash units.
// Depends on pbf_pkg and pbf_hash.

// The block keeps a Bloom filter of FILTER_BITS bits over unordered pairs of
// 32-bit variable indices. Each input transaction carries an action (insert or
// test) and two indices; the pair is put in order, packed as smaller<<32|larger,
// and hashed twice by the 64-bit finalizer (once on the packed word, once on the
// word plus the golden-ratio step). Three bit positions come from the low and
// high halves of the first hash and the low half of the second, each masked to
// the filter size. An insert sets the three bits and returns 0; a test returns
// 1 only when all three are set. Each input transaction passes from acceptance
// to its result through the two hash units, which run side by side and each
// build a 64-bit multiply from three passes through one 32x32 multiplier, then
// through three read-modify-write rounds, each a read state and a write state,
// on the bit store, which has one read and one write port, and then through the
// load of the result register. A new transaction is accepted in the cycle
// after that load, even while the previous result still waits in the output
// register; no transaction is taken before the last one is through.
// The result load itself waits until the output register is free, so a result
// that the downstream side has not yet taken holds back the next one and,
// through it, the transaction after that. After reset the bit store is cleared
// one 32-bit row per cycle, and no transaction is accepted until all are clear.
module pair_bloom_filter #(
    parameter int unsigned FILTER_BITS = pbf_pkg::FILTER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_var_first,
    input  logic [31:0] s_var_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_maybe_present
);

    localparam int unsigned ROW_BITS = pbf_pkg::ROW_BITS;
    localparam int unsigned BIT_W    = $clog2(ROW_BITS);
    localparam int unsigned POS_W    = $clog2(FILTER_BITS);
    localparam int unsigned ROWS     = FILTER_BITS / ROW_BITS;
    localparam int unsigned ROW_W    = $clog2(ROWS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [ROW_W-1:0] clr_addr_reg, clr_addr_next;
    logic [1:0] slot_reg, slot_next;
    logic       action_reg, action_next;
    logic       hit_reg, hit_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_maybe_present_reg, m_maybe_present_next;

    // Pair ordering and packing.
    logic        first_smaller;
    logic [63:0] pair_word;
    logic [63:0] pair_word_step;
    logic        accept;

    // Hash units.
    logic        hash_a_done;
    logic        hash_b_done;
    logic [63:0] hash_a;
    logic [63:0] hash_b;

    // Bit store.
    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [POS_W-1:0]    pos;
    logic [ROW_W-1:0]    row;
    logic [BIT_W-1:0]    bit_sel;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                hit_bit;

    assign accept         = s_valid && s_ready;
    assign first_smaller  = s_var_first < s_var_second;
    assign pair_word      = first_smaller ? {s_var_first, s_var_second}
                                          : {s_var_second, s_var_first};
    assign pair_word_step = pair_word + pbf_pkg::GOLDEN_STEP;

    pbf_hash u_hash_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (pair_word),
        .done    (hash_a_done),
        .result  (hash_a)
    );

    pbf_hash u_hash_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (pair_word_step),
        .done    (hash_b_done),
        .result  (hash_b)
    );

    // The hash units hold their results while the store rounds run, so the
    // position of the current round is a plain select on the round counter.
    always_comb begin
        unique case (slot_reg)
            2'd0:    pos = hash_a[POS_W-1:0];
            2'd1:    pos = hash_a[32 +: POS_W];
            2'd2:    pos = hash_b[POS_W-1:0];
            default: pos = '0;
        endcase
    end

    assign row     = pos[POS_W-1:BIT_W];
    assign bit_sel = pos[BIT_W-1:0];
    assign hit_bit = rd_data_reg[bit_sel];

    // Each round writes back before the next round issues its read, so two
    // positions in the same row never overlap and no forwarding is needed.
    assign mem_we    = (state_reg == S_CLEAR)
                    || ((state_reg == S_WR) && (action_reg == pbf_pkg::ACT_INSERT));
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : row;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0
                                              : (rd_data_reg | (ROW_BITS'(1) << bit_sel));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[row];
    end

    always_comb begin
        state_next           = state_reg;
        clr_addr_next        = clr_addr_reg;
        slot_next            = slot_reg;
        action_next          = action_reg;
        hit_next             = hit_reg;
        m_valid_next         = m_valid_reg;
        m_maybe_present_next = m_maybe_present_reg;

        // The result register is freed as soon as the downstream side takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + ROW_W'(1);
                if (clr_addr_reg == ROW_W'(ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    action_next = s_action;
                    hit_next    = 1'b1;
                    slot_next   = 2'd0;
                    state_next  = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_a_done) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                hit_next = hit_reg & hit_bit;
                if (slot_reg == 2'd2) begin
                    state_next = S_DONE;
                end else begin
                    slot_next  = slot_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_maybe_present_next = (action_reg == pbf_pkg::ACT_TEST) && hit_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            slot_reg     <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            slot_reg     <= slot_next;
            m_valid_reg  <= m_valid_next;
        end
        action_reg          <= action_next;
        hit_reg             <= hit_next;
        m_maybe_present_reg <= m_maybe_present_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_maybe_present = m_maybe_present_reg;

    // Both hash units start together and run the same number of steps.
    a_hash_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_a_done == hash_b_done)
        else $error("hash units out of step");

    // The store rounds only use the three defined positions.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_WR) |-> slot_reg != 2'd3)
        else $error("store round counter out of range");

    // An insert always reports zero.
    a_insert_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && action_reg == pbf_pkg::ACT_INSERT
         && (!m_valid_reg || m_ready))
        |=> (m_valid && !m_maybe_present))
        else $error("insert produced a nonzero result");

    // A result is loaded only after a full hash and three store rounds.
    a_done_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> ($past(state_reg) == S_WR || $past(state_reg) == S_DONE))
        else $error("result stage entered out of sequence");

endmodule

// ----- hw/rtl/pbf_hash.sv -----
// Iterative 64-bit finalizer hash built around one 32x32 multiplier.
// Each 64-bit multiply takes three partial products, and a hash runs two such multiplies.
// Depends on pbf_pkg for the multiplier constants.
module pbf_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] result
);

    typedef enum logic [1:0] {
        H_IDLE = 2'b01,
        H_MUL  = 2'b10
    } hstate_t;

    hstate_t     hstate_reg, hstate_next;
    logic [1:0]  step_reg, step_next;
    logic        pass_reg, pass_next;
    logic [63:0] k_reg, k_next;
    logic [63:0] acc_reg, acc_next;

    logic [31:0] c_lo;
    logic [31:0] c_hi;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [31:0] hi_sum;
    logic [63:0] full_prod;

    assign c_lo = pass_reg ? pbf_pkg::MIX_C2[31:0]  : pbf_pkg::MIX_C1[31:0];
    assign c_hi = pass_reg ? pbf_pkg::MIX_C2[63:32] : pbf_pkg::MIX_C1[63:32];

    // Partial products: low x low (full), high x low and low x high (low halves only).
    always_comb begin
        unique case (step_reg)
            2'd0: begin
                op_a = k_reg[31:0];
                op_b = c_lo;
            end
            2'd1: begin
                op_a = k_reg[63:32];
                op_b = c_lo;
            end
            2'd2: begin
                op_a = k_reg[31:0];
                op_b = c_hi;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod      = op_a * op_b;
    assign hi_sum    = acc_reg[63:32] + prod[31:0];
    assign full_prod = {hi_sum, acc_reg[31:0]};

    always_comb begin
        hstate_next = hstate_reg;
        step_next   = step_reg;
        pass_next   = pass_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        unique case (hstate_reg)
            H_IDLE: begin
                if (start) begin
                    k_next      = key ^ (key >> 33);
                    step_next   = 2'd0;
                    pass_next   = 1'b0;
                    hstate_next = H_MUL;
                end
            end
            H_MUL: begin
                unique case (step_reg)
                    2'd0: begin
                        acc_next  = prod;
                        step_next = 2'd1;
                    end
                    2'd1: begin
                        acc_next  = full_prod;
                        step_next = 2'd2;
                    end
                    default: begin
                        k_next    = full_prod ^ (full_prod >> 33);
                        step_next = 2'd0;
                        pass_next = 1'b1;
                        if (pass_reg) begin
                            hstate_next = H_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                hstate_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hstate_reg <= H_IDLE;
            step_reg   <= 2'd0;
            pass_reg   <= 1'b0;
        end else begin
            hstate_reg <= hstate_next;
            step_reg   <= step_next;
            pass_reg   <= pass_next;
        end
        k_reg   <= k_next;
        acc_reg <= acc_next;
    end

    assign done   = (hstate_reg == H_MUL) && (step_reg == 2'd2) && pass_reg;
    assign result = k_reg;

endmodule
